@@ rtl/upst_pkg.sv @@
// Package for the unordered pair set table: item structs, command codes and
// the cell control struct. No dependencies.
`default_nettype none
package upst_pkg;

  localparam int ELEMENT_WIDTH = 16;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int CMD_W = 2;
  localparam int TOTAL_W = 7;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef logic [ELEMENT_WIDTH-1:0] elem_t;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    elem_t            first_element;
    elem_t            second_element;
  } in_item_t;

  typedef struct packed {
    logic               was_present;
    logic               insert_refused;
    logic [TOTAL_W-1:0] entry_total;
  } out_item_t;

  typedef struct packed {
    elem_t lo;
    elem_t hi;
  } pair_t;

  typedef struct packed {
    logic cmp_en;
    logic ins;
    logic rem;
  } upst_ctl_t;

endpackage
`default_nettype wire

@@ rtl/upst_cell.sv @@
// One table cell: holds a stored pair, compares it with the key and shifts
// toward either neighbor. Depends on upst_pkg.
`default_nettype none
module upst_cell import upst_pkg::*; #(
  parameter int CELL_INDEX = 0,
  parameter int CNT_W      = 7
) (
  input  wire logic             clk,
  input  wire upst_ctl_t        ctl_i,
  input  wire pair_t            key_i,
  input  wire pair_t            left_i,
  input  wire pair_t            right_i,
  input  wire logic [CNT_W-1:0] count_i,
  input  wire logic             take_right_i,
  output pair_t                 entry_o,
  output logic                  hit_o
);

  pair_t entry_r;
  logic  hit_r;
  logic  occupied;
  logic  match;

  assign occupied = count_i > CNT_W'(CELL_INDEX);
  assign match    = occupied && (entry_r.lo == key_i.lo) && (entry_r.hi == key_i.hi);

  always_ff @(posedge clk) begin
    if (ctl_i.cmp_en) begin
      hit_r <= match;
    end
    if (ctl_i.ins) begin
      entry_r <= left_i;
    end else if (ctl_i.rem && take_right_i) begin
      entry_r <= right_i;
    end
  end

  assign entry_o = entry_r;
  assign hit_o   = hit_r;

endmodule
`default_nettype wire

@@ rtl/upst_prefix_or.sv @@
// Log-depth prefix OR over the cell hit vector; bit i is set when any cell
// at or below i matched. Depends on nothing.
`default_nettype none
module upst_prefix_or #(
  parameter int WIDTH = 64
) (
  input  wire logic [WIDTH-1:0] vec_i,
  output logic [WIDTH-1:0]      pre_o
);

  localparam int LEVELS = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] lvl [0:LEVELS];

  assign lvl[0] = vec_i;

  for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      if (i >= (1 << l)) begin : g_or
        assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
      end else begin : g_pass
        assign lvl[l+1][i] = lvl[l][i];
      end
    end
  end

  assign pre_o = lvl[LEVELS];

endmodule
`default_nettype wire

@@ rtl/unordered_pair_set_table_unit.sv @@
// Top level of the unordered pair set table: a chain of cells, control and
// the result register. Depends on upst_pkg, upst_cell and upst_prefix_or.
//
// Usage: an item on the in_ channel carries a command (insert, query or
// remove) and two elements; the pair is stored with its smaller element first.
// Every item gives exactly one result item on the out_ channel with the
// presence flag, the refusal flag and the entry count after the item.
// Sequence: the item is accepted, all cells compare against it in the compare
// state, and the update state then updates the chain and loads the result
// register, which raises out_valid.
// The update state follows the compare state; a new item is taken in the
// update state of the last one, once the result register can take its result.
// Insert shifts the chain one cell up from the head, remove closes the gap by
// shifting the cells above the match one cell down.
// Reset clears the state, the count and the output valid flag; cell contents
// need no clearing since only cells below the count are compared.
// When the receiver stalls, the finished result waits in the output register
// and the next item waits in its update cycle until that register frees.
`default_nettype none
module unordered_pair_set_table_unit import upst_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r;
  logic [CMD_W-1:0] cmd_r;
  elem_t            a_r, b_r;

  pair_t                  key;
  pair_t                  entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit_vec;
  logic [TABLE_DEPTH-1:0] pre_vec;
  logic                   any_hit;
  logic                   commit;
  logic                   accept;
  logic                   refuse;
  upst_ctl_t              ctl;

  assign key.lo = (a_r < b_r) ? a_r : b_r;
  assign key.hi = (a_r < b_r) ? b_r : a_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    pair_t left_pair;
    pair_t right_pair;
    if (i == 0) begin : g_head
      assign left_pair = key;
    end else begin : g_mid
      assign left_pair = entry[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign right_pair = entry[i];
    end else begin : g_next
      assign right_pair = entry[i+1];
    end
    upst_cell #(
      .CELL_INDEX (i),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .key_i        (key),
      .left_i       (left_pair),
      .right_i      (right_pair),
      .count_i      (count_r),
      .take_right_i (pre_vec[i]),
      .entry_o      (entry[i]),
      .hit_o        (hit_vec[i])
    );
  end

  upst_prefix_or #(
    .WIDTH (TABLE_DEPTH)
  ) u_prefix (
    .vec_i (hit_vec),
    .pre_o (pre_vec)
  );

  assign any_hit  = pre_vec[TABLE_DEPTH-1];
  assign commit   = (state_r == ST_UPD) && (!out_valid_r || out_ready);
  assign in_ready = (state_r == ST_IDLE) || commit;
  assign accept   = in_valid && in_ready;
  assign refuse   = (cmd_r == CMD_INSERT) && !any_hit && (count_r == FULL_COUNT);

  assign ctl.cmp_en = (state_r == ST_CMP);
  assign ctl.ins    = commit && (cmd_r == CMD_INSERT) && !any_hit && (count_r != FULL_COUNT);
  assign ctl.rem    = commit && (cmd_r == CMD_REMOVE) && any_hit;

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (commit) begin
          state_nxt = accept ? ST_CMP : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = commit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      a_r   <= in_data.first_element;
      b_r   <= in_data.second_element;
    end
    if (commit) begin
      out_data_r.was_present    <= any_hit;
      out_data_r.insert_refused <= refuse;
      out_data_r.entry_total    <= TOTAL_W'(count_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> $onehot0(hit_vec))
    else $error("More than one cell holds the same pair.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_COUNT)
    else $error("Entry count exceeds the table depth.");

  a_accept_to_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == ST_CMP))
    else $error("Accepted item did not enter the compare cycle.");

  a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rem |=> (count_r == $past(count_r) - CNT_W'(1)))
    else $error("Remove did not decrement the entry count.");

  a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && refuse) |=> (count_r == FULL_COUNT) && out_data_r.insert_refused)
    else $error("Refused insert changed the count or lost its flag.");
`endif

endmodule
`default_nettype wire
